/* hw/rtl/packet_crc32_trailer_checker_unit_macros.svh */
// ----------------------------------------------------------------------------
// packet crc32 trailer checker assertion macros
// shared assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef PACKET_CRC32_TRAILER_CHECKER_UNIT_MACROS_SVH
`define PACKET_CRC32_TRAILER_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is low
`define PCRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define PCRC_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pcrc_pkg.sv */
// ----------------------------------------------------------------------------
// pcrc_pkg
// types, constants and the byte-wise crc-32 fold for the trailer checker
// ----------------------------------------------------------------------------
package pcrc_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] HEAD_MARKER   = 32'hAA55_AA55;
    localparam int          TRAILER_LEN   = 4;
    localparam int          MAX_BYTES_DEF = 1024;
    localparam int          BYTE_COUNT_W  = 11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic                    crc_match;
        logic                    too_short;
        logic                    marker_ok;
        logic [31:0]             computed_crc;
        logic [BYTE_COUNT_W-1:0] byte_count;
    } t_result;

    // reflected crc-32, eight bit steps unrolled
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                  input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/pcrc_in_stage.sv */
// ----------------------------------------------------------------------------
// pcrc_in_stage
// input register for one received word, with stall toward the sender
// ----------------------------------------------------------------------------
module pcrc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pcrc_pkg::t_in_word  i_word,
    output logic                o_stall,
    input  logic                i_out_free,
    output logic                o_fire,
    output pcrc_pkg::t_in_word  o_word
);

    logic               r_vld;
    pcrc_pkg::t_in_word r_word;
    logic               accept;

    // only a last word needs room in the result register
    assign o_fire  = r_vld && (!r_word.last_byte || i_out_free);
    assign o_stall = !i_rst_n || (r_vld && !o_fire);
    assign accept  = i_valid && !o_stall;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_fire) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
        end
    end

endmodule

/* hw/rtl/pcrc_core.sv */
// ----------------------------------------------------------------------------
// pcrc_core
// packet state: delay line, crc register, byte count and first word
// ----------------------------------------------------------------------------
module pcrc_core #(
    parameter int MAX_BYTES = pcrc_pkg::MAX_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  pcrc_pkg::t_in_word i_word,
    output logic               o_result_vld,
    output pcrc_pkg::t_result  o_result
);

    localparam int CW = $clog2(MAX_BYTES + 1);

    logic [31:0]      r_crc,   n_crc;
    logic [3:0][7:0]  r_dly,   n_dly;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_first, n_first;
    logic             short_pkt;
    logic [31:0]      final_crc;
    logic [CW+pcrc_pkg::BYTE_COUNT_W-1:0] cnt_ext;

    always_comb begin
        n_crc   = r_crc;
        n_dly   = r_dly;
        n_count = r_count;
        n_first = r_first;
        if (r_count < CW'(MAX_BYTES)) begin
            // the byte leaving the delay line is past the trailer window
            if (r_count >= CW'(pcrc_pkg::TRAILER_LEN)) begin
                n_crc = pcrc_pkg::crc_fold_byte(r_crc, r_dly[0]);
            end
            n_dly = {i_word.data_byte, r_dly[3:1]};
            if (r_count < CW'(pcrc_pkg::TRAILER_LEN)) begin
                n_first[{r_count[1:0], 3'b000} +: 8] = i_word.data_byte;
            end
            n_count = r_count + CW'(1);
        end
    end

    assign short_pkt = n_count < CW'(pcrc_pkg::TRAILER_LEN);
    assign final_crc = ~n_crc;
    assign cnt_ext   = {{pcrc_pkg::BYTE_COUNT_W{1'b0}}, n_count};

    assign o_result_vld          = i_fire && i_word.last_byte;
    assign o_result.crc_match    = !short_pkt && (final_crc == n_dly);
    assign o_result.too_short    = short_pkt;
    assign o_result.marker_ok    = !short_pkt && (n_first == pcrc_pkg::HEAD_MARKER);
    assign o_result.computed_crc = final_crc;
    assign o_result.byte_count   = cnt_ext[pcrc_pkg::BYTE_COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_result_vld) begin
            r_crc   <= pcrc_pkg::CRC_INIT;
            r_dly   <= '0;
            r_count <= '0;
            r_first <= '0;
        end else if (i_fire) begin
            r_crc   <= n_crc;
            r_dly   <= n_dly;
            r_count <= n_count;
            r_first <= n_first;
        end
    end

endmodule

/* hw/rtl/pcrc_out_stage.sv */
// ----------------------------------------------------------------------------
// pcrc_out_stage
// result register facing the receiver
// ----------------------------------------------------------------------------
module pcrc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pcrc_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output pcrc_pkg::t_result o_result
);

    logic              r_vld;
    pcrc_pkg::t_result r_result;

    assign o_free   = !r_vld || !i_stall;
    assign o_valid  = r_vld;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hw/rtl/packet_crc32_trailer_checker_unit.sv */
// ----------------------------------------------------------------------------
// packet_crc32_trailer_checker_unit
// checks the little-endian crc-32 trailer of a byte-serial packet
// ----------------------------------------------------------------------------
// input channel: one byte per word on i_data_byte, i_last_byte on the final
// byte; a word is taken when i_in_valid is high and o_in_stall is low.
// output channel: one result word per packet, taken when o_out_valid is high
// and i_out_stall is low: crc match, too-short and marker flags, the
// computed crc over all bytes but the last four, and the byte count.
// throughput: one byte per cycle while no last byte waits on a stalled result,
// set by the byte-wide crc fold that sits between the input register and the
// result register. a packet's result is loaded into the result register when
// its last byte leaves the input register, and then shows on o_out_valid.
// bytes past MAX_BYTES in one packet are dropped; their last flag still
// closes the packet.
// when the receiver stalls, the result holds and non-last bytes keep flowing;
// a last byte waits in the input register, and o_in_stall rises behind it.
// reset clears the packet state and the valid flags of both registers;
// o_in_stall is high while reset is low.
// ----------------------------------------------------------------------------
module packet_crc32_trailer_checker_unit #(
    parameter int MAX_BYTES = pcrc_pkg::MAX_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_crc_match,
    output logic                              o_too_short,
    output logic                              o_marker_ok,
    output logic [31:0]                       o_computed_crc,
    output logic [pcrc_pkg::BYTE_COUNT_W-1:0] o_byte_count
);

    pcrc_pkg::t_in_word in_word;
    pcrc_pkg::t_in_word stage_word;
    pcrc_pkg::t_result  core_result;
    pcrc_pkg::t_result  out_result;
    logic               out_free;
    logic               fire;
    logic               result_vld;

    assign in_word.data_byte = i_data_byte;
    assign in_word.last_byte = i_last_byte;

    pcrc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_word     (in_word),
        .o_stall    (o_in_stall),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_word     (stage_word)
    );

    pcrc_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_word       (stage_word),
        .o_result_vld (result_vld),
        .o_result     (core_result)
    );

    pcrc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (result_vld),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_crc_match    = out_result.crc_match;
    assign o_too_short    = out_result.too_short;
    assign o_marker_ok    = out_result.marker_ok;
    assign o_computed_crc = out_result.computed_crc;
    assign o_byte_count   = out_result.byte_count;

endmodule

/* hw/rtl/pcrc_checker.sv */
// ----------------------------------------------------------------------------
// pcrc_checker
// port-level checks for the crc32 trailer checker, bound to the top level
// ----------------------------------------------------------------------------
`include "packet_crc32_trailer_checker_unit_macros.svh"

module pcrc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [7:0]                        i_data_byte,
    input logic                              i_last_byte,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_crc_match,
    input logic                              o_too_short,
    input logic                              o_marker_ok,
    input logic [31:0]                       o_computed_crc,
    input logic [pcrc_pkg::BYTE_COUNT_W-1:0] o_byte_count
);

    // a stalled result word holds
    `PCRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && o_out_valid && i_out_stall, !i_rst_n || (o_out_valid && $stable(o_computed_crc) && $stable(o_byte_count)), "result word changed while stalled")

    // a stalled input word holds
    `PCRC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n && i_in_valid && o_in_stall, !i_rst_n || (i_in_valid && $stable(i_data_byte) && $stable(i_last_byte)), "input word changed while stalled")

    // no result right after reset
    `PCRC_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

    // the input only backs up behind a stalled result
    `PCRC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a stalled result")

    // a short packet reports no match, no marker and an untouched crc
    `PCRC_ASSERT_IMPL(a_short_fields, i_clk, i_rst_n, o_out_valid && o_too_short, !o_crc_match && !o_marker_ok && (o_computed_crc == 32'h0) && (o_byte_count < 11'd4), "short packet fields inconsistent")

endmodule

bind packet_crc32_trailer_checker_unit pcrc_checker u_pcrc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_data_byte    (i_data_byte),
    .i_last_byte    (i_last_byte),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_crc_match    (o_crc_match),
    .o_too_short    (o_too_short),
    .o_marker_ok    (o_marker_ok),
    .o_computed_crc (o_computed_crc),
    .o_byte_count   (o_byte_count)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for packet_crc32_trailer_checker_unit: a short table of
// hand-picked bytes, then random framed, broken and short packets; each
// result word is compared field by field with its table entry or a local predictor
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PKT_LIMIT = pcrc_pkg::MAX_BYTES_DEF;
    localparam int CNT_W = pcrc_pkg::BYTE_COUNT_W;
    localparam int RANDOM_ITEMS_PER_PHASE = 200;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_data_byte;
    logic             i_last_byte;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_crc_match;
    logic             o_too_short;
    logic             o_marker_ok;
    logic [31:0]      o_computed_crc;
    logic [CNT_W-1:0] o_byte_count;

    packet_crc32_trailer_checker_unit #(
        .MAX_BYTES(PKT_LIMIT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_crc_match    (o_crc_match),
        .o_too_short    (o_too_short),
        .o_marker_ok    (o_marker_ok),
        .o_computed_crc (o_computed_crc),
        .o_byte_count   (o_byte_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    typedef struct {
        logic [7:0]        data;
        logic              last;
        bit                typed;
        pcrc_pkg::t_result want;
    } t_dir_row;

    // result bits: crc_match, too_short, marker_ok, computed_crc, byte_count
    t_dir_row directed_rows [25] = '{
        '{8'hFF, 1'b1, 1'b1, {1'b0, 1'b1, 1'b0, 32'h0, 11'd1}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b1, {1'b0, 1'b1, 1'b0, 32'h0, 11'd2}},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'h56, 1'b1, 1'b1, {1'b0, 1'b1, 1'b0, 32'h0, 11'd3}},
        // marker word alone: empty crc is zero, trailer is the marker
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b1, 1'b1, {1'b0, 1'b0, 1'b1, 32'h0, 11'd4}},
        // zero trailer matches the empty crc
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, {1'b1, 1'b0, 1'b0, 32'h0, 11'd4}},
        // one zero byte followed by its crc
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h8D, 1'b0, 1'b0, '0},
        '{8'hEF, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'hD2, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'hC3, 1'b1, 1'b0, '0}
    };

    // predictor state
    logic [31:0] pred_crc;
    logic [7:0]  pred_hold [4];
    int unsigned pred_count;
    logic [31:0] pred_head;

    pcrc_pkg::t_result expected_results [$];
    logic [7:0]        pkt_bytes [$];
    int                mismatches = 0;
    int                items_sent = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    // reflected crc-32, one data bit at a time
    function automatic logic [31:0] crc_shift_in(input logic [31:0] crc,
                                                 input logic [7:0]  b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ pcrc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void pred_clear();
        pred_crc   = pcrc_pkg::CRC_INIT;
        pred_hold  = '{default: 8'h00};
        pred_count = 0;
        pred_head  = '0;
    endfunction

    function automatic bit pred_take_byte(input logic [7:0] b, input logic last,
                                          output pcrc_pkg::t_result r);
        logic [31:0] trailer;
        logic [31:0] crc_final;
        bit          short_pkt;
        r = '0;
        if (pred_count < PKT_LIMIT) begin
            if (pred_count >= pcrc_pkg::TRAILER_LEN) begin
                pred_crc = crc_shift_in(pred_crc, pred_hold[0]);
            end
            pred_hold[0] = pred_hold[1];
            pred_hold[1] = pred_hold[2];
            pred_hold[2] = pred_hold[3];
            pred_hold[3] = b;
            if (pred_count < pcrc_pkg::TRAILER_LEN) begin
                pred_head[8*pred_count +: 8] = b;
            end
            pred_count++;
        end
        if (!last) begin
            return 1'b0;
        end
        trailer   = {pred_hold[3], pred_hold[2], pred_hold[1], pred_hold[0]};
        short_pkt = pred_count < pcrc_pkg::TRAILER_LEN;
        crc_final = ~pred_crc;
        r.crc_match    = !short_pkt && (crc_final == trailer);
        r.too_short    = short_pkt;
        r.marker_ok    = !short_pkt && (pred_head == pcrc_pkg::HEAD_MARKER);
        r.computed_crc = crc_final;
        r.byte_count   = CNT_W'(pred_count);
        pred_clear();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch_results
        pcrc_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result word with nothing expected: crc %h count %0d",
                             o_computed_crc, o_byte_count);
                end
            end else begin
                want = expected_results.pop_front();
                check_field("crc_match", 32'(want.crc_match), 32'(o_crc_match));
                check_field("too_short", 32'(want.too_short), 32'(o_too_short));
                check_field("marker_ok", 32'(want.marker_ok), 32'(o_marker_ok));
                check_field("computed_crc", want.computed_crc, o_computed_crc);
                check_field("byte_count", 32'(want.byte_count), 32'(o_byte_count));
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input pcrc_pkg::t_result typed_res);
        pcrc_pkg::t_result r;
        bit                has_result;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        has_result = pred_take_byte(b, last, r);
        if (has_result) begin
            expected_results.push_back(typed ? typed_res : r);
        end
        items_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            send_byte(pkt_bytes[i], (i == pkt_bytes.size() - 1), 1'b0, '0);
        end
    endtask

    // hold the sender off until every result word is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // body followed by its crc as a little-endian trailer
    task automatic build_framed(input int body_len, input bit with_marker);
        logic [31:0] crc;
        pkt_bytes.delete();
        if (with_marker) begin
            for (int i = 0; i < 4; i++) begin
                pkt_bytes.push_back(8'(pcrc_pkg::HEAD_MARKER >> (8 * i)));
            end
        end
        while (pkt_bytes.size() < body_len) begin
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        crc = pcrc_pkg::CRC_INIT;
        foreach (pkt_bytes[i]) begin
            crc = crc_shift_in(crc, pkt_bytes[i]);
        end
        crc = ~crc;
        for (int i = 0; i < 4; i++) begin
            pkt_bytes.push_back(8'(crc >> (8 * i)));
        end
    endtask

    task automatic build_noise(input int len);
        pkt_bytes.delete();
        repeat (len) begin
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_random_packet();
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            build_noise($urandom_range(1, 3));
        end else if (kind < 20) begin
            build_noise($urandom_range(4, 12));
        end else begin
            build_framed($urandom_range(0, 16), ($urandom_range(0, 99) < 30));
            // single bit error somewhere in body or trailer
            if ($urandom_range(0, 99) < 20) begin
                pick = $urandom_range(0, pkt_bytes.size() - 1);
                pkt_bytes[pick] ^= 8'h01 << $urandom_range(0, 7);
            end
        end
    endtask

    initial begin
        int phase_goal;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_out_stall = 1'b0;
        pred_clear();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 64;
        foreach (directed_rows[k]) begin
            send_byte(directed_rows[k].data, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].want);
        end
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 12 : 0;
            phase_goal = items_sent + RANDOM_ITEMS_PER_PHASE;
            while (items_sent < phase_goal) begin
                build_random_packet();
                send_packet();
                if ($urandom_range(0, 99) < 4) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int n = 0; n < 5000 && expected_results.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d result words never arrived", expected_results.size());
            mismatches += expected_results.size();
        end
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
